[src/dsrp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the deferred swap-remove pool.
package dsrp_pkg;

    localparam int DSRP_MAX_ELEMENTS  = 65536;
    localparam int DSRP_PENDING_DEPTH = 32;

    localparam int IDX_W = 16;
    localparam int CNT_W = 17;

    typedef enum logic [1:0] {
        FUNC_REMOVE = 2'd0,
        FUNC_SPAWN  = 2'd1,
        FUNC_COMMIT = 2'd2,
        FUNC_NOP    = 2'd3
    } dsrp_func_t;

    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_GRANT  = 2'd2
    } dsrp_kind_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_DUP   = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FULL  = 2'd3
    } dsrp_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DUP_SCAN,
        S_ACK,
        S_POP,
        S_POP_DATA,
        S_FIX_SCAN,
        S_REM_OUT,
        S_GRANT_CALC,
        S_GRANT
    } dsrp_state_t;

    typedef struct packed {
        logic [1:0]       func;
        logic [IDX_W-1:0] elem_index;
        logic [CNT_W-1:0] spawn_count;
    } dsrp_in_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] slot_index;
        logic             move_valid;
        logic [IDX_W-1:0] move_from;
        logic [CNT_W-1:0] granted_count;
        logic [CNT_W-1:0] active_count;
        logic [CNT_W-1:0] high_water;
        logic [1:0]       status;
        logic             last;
    } dsrp_out_t;

endpackage

[src/dsrp_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write port, one registered read port.
module dsrp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/deferred_swap_remove_pool_top.sv]
`timescale 1ns / 1ps
// Dense element pool with deferred swap-and-pop removal and deferred spawning.
//
// Pending removals live in a small RAM with one read and one write port; every
// read of the list goes through that single read port, one entry per cycle.
// Spawn requests and no-ops are acknowledged directly. A removal request first
// scans the queued entries for a duplicate. A commit pops the entries newest
// first and, for each removal that moves the last element, scans the remaining
// entries to retarget the one naming it; the grant follows the last pop.
// Results leave through an output register, so a new item is taken while the
// last result waits.
// Capacity is written on the cfg channel while the pool is idle.
module deferred_swap_remove_pool_top #(
    parameter int PENDING_DEPTH = dsrp_pkg::DSRP_PENDING_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  dsrp_pkg::dsrp_in_t         in_item,
    output logic                       out_valid,
    input  logic                       out_stall,
    output dsrp_pkg::dsrp_out_t        out_item,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [dsrp_pkg::CNT_W-1:0] cfg_data
);

    import dsrp_pkg::*;

    localparam int LEN_W  = $clog2(PENDING_DEPTH + 1);
    localparam int ADDR_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(PENDING_DEPTH);
    localparam logic [31:0] MAX_CAP = 32'(DSRP_MAX_ELEMENTS);

    dsrp_state_t       state_reg, state_next;
    dsrp_in_t          op_reg, op_next;
    logic [CNT_W-1:0]  cap_reg, cap_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  spawn_reg, spawn_next;
    logic [CNT_W-1:0]  active_reg, active_next;
    logic [CNT_W-1:0]  peak_reg, peak_next;
    logic [LEN_W-1:0]  issue_reg, issue_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [ADDR_W-1:0] chk_addr_reg, chk_addr_next;
    logic              dup_reg, dup_next;
    logic [IDX_W-1:0]  victim_reg, victim_next;
    logic              move_reg, move_next;
    logic [CNT_W-1:0]  granted_reg, granted_next;
    dsrp_out_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [IDX_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [IDX_W-1:0]  ram_rdata;

    logic              out_free;
    logic              emit;
    logic [CNT_W-1:0]  last_idx;
    logic [LEN_W-1:0]  len_m1;
    logic [CNT_W-1:0]  scan_key;
    logic              scan_hit;
    logic              scan_more;
    logic [CNT_W-1:0]  cap_sat;
    logic [CNT_W:0]    spawn_sum;
    logic [CNT_W-1:0]  spawn_sat;
    logic [CNT_W-1:0]  free_space;
    logic [CNT_W-1:0]  grant_active;
    logic [CNT_W-1:0]  grant_peak;
    dsrp_status_t      ack_status;

    dsrp_ram #(
        .WIDTH (IDX_W),
        .DEPTH (PENDING_DEPTH)
    ) u_pending_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign last_idx  = active_reg - CNT_W'(1);
    assign len_m1    = len_reg - LEN_W'(1);
    assign scan_key  = (state_reg == S_FIX_SCAN) ? last_idx : {1'b0, op_reg.elem_index};
    assign scan_hit  = chk_vld_reg && ({1'b0, ram_rdata} == scan_key);
    assign scan_more = (issue_reg < len_reg);

    assign cap_sat    = ({15'd0, cfg_data} > MAX_CAP) ? MAX_CAP[CNT_W-1:0] : cfg_data;
    assign spawn_sum  = {1'b0, spawn_reg} + {1'b0, op_reg.spawn_count};
    assign spawn_sat  = (spawn_sum > {1'b0, cap_reg}) ? cap_reg : spawn_sum[CNT_W-1:0];
    assign free_space = (cap_reg > active_reg) ? (cap_reg - active_reg) : '0;
    assign grant_active = active_reg + granted_reg;
    assign grant_peak = ((spawn_reg != '0) && (grant_active > peak_reg)) ? grant_active
                                                                         : peak_reg;

    always_comb
    begin
        if (dup_reg)
        begin
            ack_status = STAT_DUP;
        end
        else if ({1'b0, op_reg.elem_index} >= active_reg)
        begin
            ack_status = STAT_RANGE;
        end
        else if (len_reg >= DEPTH_LEN)
        begin
            ack_status = STAT_FULL;
        end
        else
        begin
            ack_status = STAT_OK;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        cap_next      = cap_reg;
        len_next      = len_reg;
        spawn_next    = spawn_reg;
        active_next   = active_reg;
        peak_next     = peak_reg;
        issue_next    = issue_reg;
        chk_vld_next  = 1'b0;
        chk_addr_next = chk_addr_reg;
        dup_next      = dup_reg;
        victim_next   = victim_reg;
        move_next     = move_reg;
        granted_next  = granted_reg;
        out_next      = out_reg;
        emit          = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = len_reg[ADDR_W-1:0];
        ram_wdata     = op_reg.elem_index;
        ram_raddr     = issue_reg[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_item;
                    issue_next = '0;
                    dup_next   = 1'b0;
                    case (in_item.func)
                        FUNC_REMOVE: state_next = S_DUP_SCAN;
                        FUNC_COMMIT: state_next = S_POP;
                        default:     state_next = S_ACK;
                    endcase
                end
            end

            S_DUP_SCAN, S_FIX_SCAN:
            begin
                if (scan_hit)
                begin
                    if (state_reg == S_FIX_SCAN)
                    begin
                        // retarget the entry naming the old last element
                        ram_we     = 1'b1;
                        ram_waddr  = chk_addr_reg;
                        ram_wdata  = victim_reg;
                        state_next = S_REM_OUT;
                    end
                    else
                    begin
                        dup_next   = 1'b1;
                        state_next = S_ACK;
                    end
                end
                else if (scan_more)
                begin
                    ram_raddr     = issue_reg[ADDR_W-1:0];
                    chk_addr_next = issue_reg[ADDR_W-1:0];
                    issue_next    = issue_reg + LEN_W'(1);
                    chk_vld_next  = 1'b1;
                end
                else if (!chk_vld_reg)
                begin
                    state_next = (state_reg == S_FIX_SCAN) ? S_REM_OUT : S_ACK;
                end
            end

            S_ACK:
            begin
                if (out_free)
                begin
                    emit     = 1'b1;
                    out_next = '0;
                    out_next.kind = KIND_ACK;
                    case (op_reg.func)
                        FUNC_REMOVE:
                        begin
                            out_next.slot_index = op_reg.elem_index;
                            out_next.status     = ack_status;
                            if (ack_status == STAT_OK)
                            begin
                                ram_we   = 1'b1;
                                len_next = len_reg + LEN_W'(1);
                            end
                        end
                        FUNC_SPAWN:
                        begin
                            spawn_next = spawn_sat;
                        end
                        default:
                        begin
                        end
                    endcase
                    out_next.active_count = active_reg;
                    out_next.high_water   = peak_reg;
                    out_next.last         = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            S_POP:
            begin
                if ((len_reg == '0) || (active_reg == '0))
                begin
                    len_next   = '0;
                    state_next = S_GRANT_CALC;
                end
                else
                begin
                    ram_raddr  = len_m1[ADDR_W-1:0];
                    len_next   = len_m1;
                    state_next = S_POP_DATA;
                end
            end

            S_POP_DATA:
            begin
                victim_next = ram_rdata;
                if ({1'b0, ram_rdata} >= last_idx)
                begin
                    move_next  = 1'b0;
                    state_next = S_REM_OUT;
                end
                else
                begin
                    move_next  = 1'b1;
                    issue_next = '0;
                    state_next = S_FIX_SCAN;
                end
            end

            S_REM_OUT:
            begin
                if (out_free)
                begin
                    emit     = 1'b1;
                    out_next = '0;
                    out_next.kind         = KIND_REMOVE;
                    out_next.slot_index   = victim_reg;
                    out_next.move_valid   = move_reg;
                    out_next.move_from    = move_reg ? last_idx[IDX_W-1:0] : '0;
                    out_next.active_count = last_idx;
                    out_next.high_water   = peak_reg;
                    out_next.status       = STAT_OK;
                    active_next           = last_idx;
                    state_next            = S_POP;
                end
            end

            S_GRANT_CALC:
            begin
                if (spawn_reg == '0)
                begin
                    granted_next = '0;
                end
                else
                begin
                    granted_next = (spawn_reg < free_space) ? spawn_reg : free_space;
                end
                state_next = S_GRANT;
            end

            S_GRANT:
            begin
                if (out_free)
                begin
                    emit     = 1'b1;
                    out_next = '0;
                    out_next.kind          = KIND_GRANT;
                    out_next.slot_index    = active_reg[IDX_W-1:0];
                    out_next.granted_count = granted_reg;
                    out_next.active_count  = grant_active;
                    out_next.high_water    = grant_peak;
                    out_next.status        = STAT_OK;
                    out_next.last          = 1'b1;
                    active_next            = grant_active;
                    peak_next              = grant_peak;
                    spawn_next             = '0;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready && (cap_sat != cap_reg))
        begin
            cap_next   = cap_sat;
            len_next   = '0;
            spawn_next = '0;
            peak_next  = '0;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= '0;
            len_reg       <= '0;
            spawn_reg     <= '0;
            active_reg    <= '0;
            peak_reg      <= '0;
            issue_reg     <= '0;
            chk_vld_reg   <= 1'b0;
            dup_reg       <= 1'b0;
            move_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            len_reg       <= len_next;
            spawn_reg     <= spawn_next;
            active_reg    <= active_next;
            peak_reg      <= peak_next;
            issue_reg     <= issue_next;
            chk_vld_reg   <= chk_vld_next;
            dup_reg       <= dup_next;
            move_reg      <= move_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        chk_addr_reg <= chk_addr_next;
        victim_reg   <= victim_next;
        granted_reg  <= granted_next;
        out_reg      <= out_next;
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= DEPTH_LEN)
        else $error("pending length beyond list depth");

    a_spawn_cap: assert property (@(posedge clk) disable iff (!rst_n)
        spawn_reg <= cap_reg)
        else $error("spawn total above capacity");

    a_wr_addr: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (LEN_W'(ram_waddr) <= len_reg))
        else $error("pending list write beyond fill level");

endmodule

[tb/sv/deferred_swap_remove_pool_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the deferred swap-remove pool: directed and random items.
module deferred_swap_remove_pool_top_tb;
    import dsrp_pkg::*;

    localparam int PEND = DSRP_PENDING_DEPTH;
    localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(DSRP_MAX_ELEMENTS);
    localparam int HOLD_AT = 330;
    localparam int HOLD_CYCLES = 500;
    localparam int PHASE_ITEMS = 62;

    typedef struct packed {
        logic [CNT_W-1:0]            cap;
        logic [PEND-1:0][IDX_W-1:0]  list;
        logic [5:0]                  len;
        logic [CNT_W-1:0]            spawn;
        logic [CNT_W-1:0]            active;
        logic [CNT_W-1:0]            peak;
    } pool_state_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    dsrp_in_t         in_item = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    dsrp_out_t        out_item;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data = '0;

    dsrp_in_t    pending_items[$];
    dsrp_out_t   expected_results[$];
    pool_state_t gen_pool = '0;
    pool_state_t pred_pool = '0;
    dsrp_out_t   want;
    int          errors = 0;
    int          items_taken = 0;
    int          tx_idle_pct = 22;
    int          rx_idle_pct = 60;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    deferred_swap_remove_pool_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic void pool_config(inout pool_state_t st, input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] c;
        c = (v > CAP_MAX) ? CAP_MAX : v;
        if (c != st.cap)
        begin
            st.cap = c;
            st.len = '0;
            st.spawn = '0;
            st.peak = '0;
        end
    endfunction

    // Applies one item to the pool state; with keep set, queues its results.
    function automatic void pool_apply(inout pool_state_t st, input dsrp_in_t it, input bit keep);
        dsrp_out_t        r;
        logic [CNT_W-1:0] lastidx;
        logic [CNT_W-1:0] victim;
        logic [CNT_W-1:0] granted;
        logic [CNT_W-1:0] free_sp;
        logic [CNT_W:0]   sum;
        bit               hit;
        int               i;
        r = '0;
        case (it.func)
            FUNC_REMOVE:
            begin
                r.slot_index = it.elem_index;
                hit = 1'b0;
                for (i = 0; i < int'(st.len); i++)
                    if (st.list[i] == it.elem_index)
                        hit = 1'b1;
                if (hit)
                    r.status = STAT_DUP;
                else if ({1'b0, it.elem_index} >= st.active)
                    r.status = STAT_RANGE;
                else if (int'(st.len) >= PEND)
                    r.status = STAT_FULL;
                else
                begin
                    st.list[st.len] = it.elem_index;
                    st.len = st.len + 6'd1;
                end
            end
            FUNC_SPAWN:
            begin
                sum = st.spawn + it.spawn_count;
                st.spawn = (sum > {1'b0, st.cap}) ? st.cap : sum[CNT_W-1:0];
            end
            FUNC_COMMIT:
            begin
                // removals newest first, swapping the last element into the hole
                while (st.len != 0 && st.active != 0)
                begin
                    lastidx = st.active - 1'b1;
                    victim = {1'b0, st.list[st.len - 6'd1]};
                    st.len = st.len - 6'd1;
                    r = '0;
                    r.kind = KIND_REMOVE;
                    r.slot_index = victim[IDX_W-1:0];
                    if (victim < lastidx)
                    begin
                        hit = 1'b0;
                        for (i = 0; i < int'(st.len); i++)
                            if (!hit && st.list[i] == lastidx[IDX_W-1:0])
                            begin
                                st.list[i] = victim[IDX_W-1:0];
                                hit = 1'b1;
                            end
                        r.move_valid = 1'b1;
                        r.move_from = lastidx[IDX_W-1:0];
                    end
                    st.active = st.active - 1'b1;
                    r.active_count = st.active;
                    r.high_water = st.peak;
                    if (keep)
                        expected_results.push_back(r);
                end
                st.len = '0;
                r = '0;
                r.kind = KIND_GRANT;
                r.slot_index = st.active[IDX_W-1:0];
                granted = '0;
                if (st.spawn != 0)
                begin
                    free_sp = (st.cap > st.active) ? st.cap - st.active : '0;
                    granted = (st.spawn < free_sp) ? st.spawn : free_sp;
                    st.active = st.active + granted;
                    if (st.active > st.peak)
                        st.peak = st.active;
                    st.spawn = '0;
                end
                r.granted_count = granted;
            end
            default:
            begin
            end
        endcase
        if (it.func != FUNC_COMMIT)
            r.kind = KIND_ACK;
        r.active_count = st.active;
        r.high_water = st.peak;
        r.last = 1'b1;
        if (keep)
            expected_results.push_back(r);
    endfunction

    function automatic string show(dsrp_out_t r);
        return $sformatf({"kind=%0d slot=%0d mv=%0d from=%0d granted=%0d ",
                          "active=%0d hw=%0d st=%0d last=%0d"},
                         r.kind, r.slot_index, r.move_valid, r.move_from, r.granted_count,
                         r.active_count, r.high_water, r.status, r.last);
    endfunction

    task automatic queue_item(input dsrp_func_t f, input logic [IDX_W-1:0] idx,
                              input logic [CNT_W-1:0] cnt);
        dsrp_in_t it;
        it.func = f;
        it.elem_index = idx;
        it.spawn_count = cnt;
        pending_items.push_back(it);
        pool_apply(gen_pool, it, 1'b0);
    endtask

    task automatic set_capacity(input logic [CNT_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        pool_config(gen_pool, v);
        pool_config(pred_pool, v);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (12) @(posedge clk);
    endtask

    // Mostly well-formed spawn/commit and remove/commit bursts, some noise.
    task automatic fill_random(input int n);
        int               made;
        int               pick;
        int               k;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] prev;
        made = 0;
        prev = '0;
        while (made < n)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                k = $urandom_range(3, 1);
                repeat (k)
                    queue_item(FUNC_SPAWN, IDX_W'($urandom_range(65535)),
                               ($urandom_range(7) == 0) ? CNT_W'($urandom_range(65536))
                                                        : CNT_W'($urandom_range(24, 1)));
                queue_item(FUNC_COMMIT, IDX_W'($urandom_range(65535)),
                           CNT_W'($urandom_range(65536)));
                made += k + 1;
            end
            else if (pick < 80)
            begin
                k = ($urandom_range(3) == 0) ? $urandom_range(36, 28) : $urandom_range(8, 1);
                repeat (k)
                begin
                    pick = $urandom_range(9);
                    if (pick == 0)
                        idx = prev;
                    else if (pick == 1 || gen_pool.active == 0)
                        idx = IDX_W'($urandom_range(65535));
                    else
                        idx = IDX_W'($urandom_range(int'(gen_pool.active) - 1));
                    queue_item(FUNC_REMOVE, idx, CNT_W'($urandom_range(65536)));
                    prev = idx;
                end
                made += k;
                if ($urandom_range(6) != 0)
                begin
                    queue_item(FUNC_COMMIT, IDX_W'($urandom_range(65535)),
                               CNT_W'($urandom_range(65536)));
                    made++;
                end
            end
            else
            begin
                queue_item(dsrp_func_t'($urandom_range(3)), IDX_W'($urandom_range(65535)),
                           CNT_W'($urandom_range(65536)));
                made++;
            end
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                pool_apply(pred_pool, in_item, 1'b1);
                items_taken <= items_taken + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    in_item <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off to back the pool up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && items_taken >= HOLD_AT)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                if (errors < 10)
                    $display("ERROR: unexpected result %s", show(out_item));
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_item.kind !== want.kind || out_item.slot_index !== want.slot_index ||
                    out_item.move_valid !== want.move_valid ||
                    out_item.move_from !== want.move_from ||
                    out_item.granted_count !== want.granted_count ||
                    out_item.active_count !== want.active_count ||
                    out_item.high_water !== want.high_water ||
                    out_item.status !== want.status || out_item.last !== want.last)
                begin
                    if (errors < 10)
                        $display("ERROR: exp %s\n       got %s", show(want), show(out_item));
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #(40_000_000);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        logic [CNT_W-1:0] caps[6];
        int               ph;
        caps = '{17'd40, 17'd40, 17'd0, 17'd300, 17'd65535, 17'h1FFFF};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        set_capacity(17'd3);
        queue_item(FUNC_REMOVE, 16'hFFFF, 17'd0);
        queue_item(FUNC_NOP, 16'd0, 17'd0);
        queue_item(FUNC_COMMIT, 16'd0, 17'd0);
        queue_item(FUNC_SPAWN, 16'd0, 17'd65536);
        queue_item(FUNC_SPAWN, 16'd0, 17'd0);
        queue_item(FUNC_COMMIT, 16'd0, 17'd0);
        queue_item(FUNC_REMOVE, 16'd2, 17'd0);
        queue_item(FUNC_REMOVE, 16'd0, 17'd0);
        queue_item(FUNC_REMOVE, 16'd0, 17'd0);
        queue_item(FUNC_REMOVE, 16'd3, 17'd0);
        queue_item(FUNC_COMMIT, 16'd0, 17'd0);
        queue_item(FUNC_REMOVE, 16'd0, 17'd0);
        queue_item(FUNC_COMMIT, 16'd0, 17'd0);
        queue_item(FUNC_SPAWN, 16'd0, 17'd2);
        queue_item(FUNC_COMMIT, 16'd0, 17'd0);
        wait_drained();
        // pool now holds more than the new capacity
        set_capacity(17'd1);
        queue_item(FUNC_SPAWN, 16'd0, 17'd1);
        queue_item(FUNC_COMMIT, 16'd0, 17'd0);
        queue_item(FUNC_COMMIT, 16'd0, 17'd0);
        wait_drained();

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph / 2)
                0:
                begin
                    tx_idle_pct = 22;
                    rx_idle_pct = 60;
                end
                1:
                begin
                    tx_idle_pct = 60;
                    rx_idle_pct = 22;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            set_capacity(caps[ph]);
            fill_random(PHASE_ITEMS);
            wait_drained();
        end

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[deferred_swap_remove_pool_top.f]
src/dsrp_pkg.sv
src/dsrp_ram.sv
src/deferred_swap_remove_pool_top.sv
tb/sv/deferred_swap_remove_pool_top_tb.sv
